[hdl/i2crb_pkg.sv]
`default_nettype none

package i2crb_pkg;

    // Number of registers in the bank (1 to 128)
    localparam int unsigned REG_COUNT = 5;

    // Register index width and pointer width (pointer holds 0..REG_COUNT)
    localparam int unsigned IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int unsigned PTR_W = $clog2(REG_COUNT + 1);

    localparam logic [7:0]       REG_COUNT_B = 8'(REG_COUNT);
    localparam logic [PTR_W-1:0] REG_COUNT_P = PTR_W'(REG_COUNT);

    // Event codes
    localparam logic [2:0] MODE_ADDR_MATCH = 3'd0;
    localparam logic [2:0] MODE_RX_BYTE    = 3'd1;
    localparam logic [2:0] MODE_TX_BYTE    = 3'd2;
    localparam logic [2:0] MODE_BUS_STATUS = 3'd3;
    localparam logic [2:0] MODE_LOCAL_WR   = 3'd4;
    localparam logic [2:0] MODE_LOCAL_RD   = 3'd5;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // latch input word, issue bank read
        logic execute;  // update pointer, write bank, load result
    } cmd_t;

endpackage

`default_nettype wire

[hdl/i2crb_ctrl.sv]
`default_nettype none

module i2crb_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  wire logic          m_ready,
    output i2crb_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = (state_reg == ST_DONE);
    assign cmd.capture = s_valid && s_ready;
    assign cmd.execute = (state_reg == ST_EXEC);

    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> cmd.execute)
        else $error("accepted word not executed next cycle");

    a_exec_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.execute |=> m_valid)
        else $error("execute not followed by result");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid || cmd.execute) |-> !s_ready)
        else $error("input taken while a word is in flight");

endmodule

`default_nettype wire

[hdl/i2crb_dp.sv]
`default_nettype none

module i2crb_dp (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire i2crb_pkg::cmd_t        cmd,
    input  wire logic [2:0]             s_mode,
    input  wire logic [7:0]             s_data_byte,
    input  wire logic [7:0]             s_local_index,
    output logic                        m_ack_next,
    output logic [7:0]                  m_tx_byte,
    output logic [7:0]                  m_read_data
);

    localparam int unsigned IDX_W = i2crb_pkg::IDX_W;
    localparam int unsigned PTR_W = i2crb_pkg::PTR_W;

    // Architectural state
    logic [PTR_W-1:0]               reg_pointer_reg;
    logic [PTR_W-1:0]               reg_pointer_next;
    logic                           pointer_unset_reg;
    logic                           pointer_unset_next;
    logic [7:0]                     bank_mem [i2crb_pkg::REG_COUNT];
    logic [i2crb_pkg::REG_COUNT-1:0] bank_vld_reg;

    // Captured word
    logic [2:0]                     mode_reg;
    logic [7:0]                     data_reg;
    logic [7:0]                     idx_reg;
    logic [PTR_W-1:0]               eff_ptr_reg;
    logic                           rd_hit_reg;
    logic [7:0]                     rd_data_reg;

    // Capture-side logic
    logic [PTR_W-1:0]               ld_ptr;
    logic [PTR_W-1:0]               eff_ptr;
    logic                           rd_in_range;
    logic [IDX_W-1:0]               rd_addr;

    // Execute-side logic
    logic                           wr_en;
    logic [IDX_W-1:0]               wr_addr;
    logic [PTR_W-1:0]               tx_ptr_next;
    logic                           ack;
    logic [7:0]                     tx;
    logic [7:0]                     rd;

    always_comb begin
        ld_ptr  = (s_data_byte < i2crb_pkg::REG_COUNT_B) ? s_data_byte[PTR_W-1:0] : '0;
        eff_ptr = (s_mode == i2crb_pkg::MODE_TX_BYTE && pointer_unset_reg) ?
                  ld_ptr : reg_pointer_reg;
        if (s_mode == i2crb_pkg::MODE_LOCAL_RD) begin
            rd_in_range = (s_local_index < i2crb_pkg::REG_COUNT_B);
            rd_addr     = s_local_index[IDX_W-1:0];
        end else begin
            rd_in_range = (eff_ptr < i2crb_pkg::REG_COUNT_P);
            rd_addr     = eff_ptr[IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg    <= s_mode;
            data_reg    <= s_data_byte;
            idx_reg     <= s_local_index;
            eff_ptr_reg <= eff_ptr;
            rd_hit_reg  <= rd_in_range && bank_vld_reg[rd_addr];
            if (rd_in_range) begin
                rd_data_reg <= bank_mem[rd_addr];
            end
        end
    end

    always_comb begin
        reg_pointer_next   = reg_pointer_reg;
        pointer_unset_next = pointer_unset_reg;
        wr_en              = 1'b0;
        wr_addr            = reg_pointer_reg[IDX_W-1:0];
        ack                = 1'b0;
        tx                 = '0;
        rd                 = '0;
        tx_ptr_next        = (eff_ptr_reg < i2crb_pkg::REG_COUNT_P) ?
                             PTR_W'(eff_ptr_reg + 1'b1) : i2crb_pkg::REG_COUNT_P;
        case (mode_reg)
            i2crb_pkg::MODE_ADDR_MATCH: begin
                pointer_unset_next = 1'b1;
                ack                = 1'b1;
            end
            i2crb_pkg::MODE_RX_BYTE: begin
                if (pointer_unset_reg) begin
                    reg_pointer_next   = (data_reg < i2crb_pkg::REG_COUNT_B) ?
                                         data_reg[PTR_W-1:0] : '0;
                    pointer_unset_next = 1'b0;
                    ack                = 1'b1;
                end else if (reg_pointer_reg < i2crb_pkg::REG_COUNT_P) begin
                    wr_en            = 1'b1;
                    reg_pointer_next = PTR_W'(reg_pointer_reg + 1'b1);
                    ack              = 1'b1;
                end
            end
            i2crb_pkg::MODE_TX_BYTE: begin
                pointer_unset_next = 1'b0;
                reg_pointer_next   = tx_ptr_next;
                tx                 = rd_hit_reg ? rd_data_reg : '0;
                ack                = (tx_ptr_next < i2crb_pkg::REG_COUNT_P);
            end
            i2crb_pkg::MODE_BUS_STATUS: begin
                ack = 1'b1;
            end
            i2crb_pkg::MODE_LOCAL_WR: begin
                wr_en   = (idx_reg < i2crb_pkg::REG_COUNT_B);
                wr_addr = idx_reg[IDX_W-1:0];
            end
            i2crb_pkg::MODE_LOCAL_RD: begin
                rd = rd_hit_reg ? rd_data_reg : '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reg_pointer_reg   <= '0;
            pointer_unset_reg <= 1'b0;
            bank_vld_reg      <= '0;
        end else if (cmd.execute) begin
            reg_pointer_reg   <= reg_pointer_next;
            pointer_unset_reg <= pointer_unset_next;
            if (wr_en) begin
                bank_vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.execute && wr_en) begin
            bank_mem[wr_addr] <= data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            m_ack_next  <= ack;
            m_tx_byte   <= tx;
            m_read_data <= rd;
        end
    end

    a_ptr_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        reg_pointer_reg <= i2crb_pkg::REG_COUNT_P)
        else $error("pointer beyond bank end");

    a_wr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.execute && wr_en) |-> (PTR_W'(wr_addr) < i2crb_pkg::REG_COUNT_P))
        else $error("bank write out of range");

    a_addr_unset: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.execute && mode_reg == i2crb_pkg::MODE_ADDR_MATCH) |=> pointer_unset_reg)
        else $error("address match did not unset pointer");

endmodule

`default_nettype wire

[hdl/i2c_target_register_bank.sv]
`default_nettype none
// Flow: the controller walks accept, execute (pointer update and bank write),
//   result; a new word is accepted only after the result is taken (m_ready).
// Reset (aresetn low, synchronous): pointer and unset flag cleared, every
//   bank entry marked invalid so it reads as zero; no clearing pass needed.
module i2c_target_register_bank (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_mode,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic [7:0]  s_local_index,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_ack_next,
    output logic [7:0]       m_tx_byte,
    output logic [7:0]       m_read_data
);

    // Command bus from the sequencer to the datapath
    i2crb_pkg::cmd_t cmd;

    // Sequencer: one word in flight, result held until taken
    i2crb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Datapath: pointer, unset flag, register bank and result registers.
    // Bank read happens on the accept edge, write on the execute edge.
    i2crb_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .s_mode        (s_mode),
        .s_data_byte   (s_data_byte),
        .s_local_index (s_local_index),
        .m_ack_next    (m_ack_next),
        .m_tx_byte     (m_tx_byte),
        .m_read_data   (m_read_data)
    );

endmodule

`default_nettype wire
